// ----- design/arm_banked_register_file_macros.svh -----
// Assertion macros shared by the banked register file modules.
`ifndef ARM_BANKED_REGISTER_FILE_MACROS_SVH
`define ARM_BANKED_REGISTER_FILE_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define ABRF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("banked register file check failed");

// next-cycle implication
`define ABRF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("banked register file check failed");

`endif

// ----- design/abrf_pkg.sv -----
// Types, constants and mode decode for the banked register file.
package abrf_pkg;

   localparam int DATA_W        = 32;
   localparam int NUM_GENERAL   = 16;
   localparam int REG_W         = $clog2(NUM_GENERAL);
   localparam int NUM_BANKS     = 6;
   localparam int BANK_W        = $clog2(NUM_BANKS);
   localparam int NUM_FIQ_REGS  = 5;
   localparam int FIQ_IDX_W     = $clog2(NUM_FIQ_REGS);
   localparam int FIRST_FIQ_REG = 8;
   localparam int MODE_W        = 5;
   localparam int SP_REG        = 13;
   localparam int LR_REG        = 14;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
   localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
   localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
   localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
   localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
   localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;
   localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

   localparam logic [BANK_W-1:0] BANK_USR = 3'd0;
   localparam logic [BANK_W-1:0] BANK_SVC = 3'd1;
   localparam logic [BANK_W-1:0] BANK_ABT = 3'd2;
   localparam logic [BANK_W-1:0] BANK_UND = 3'd3;
   localparam logic [BANK_W-1:0] BANK_IRQ = 3'd4;
   localparam logic [BANK_W-1:0] BANK_FIQ = 3'd5;

   localparam logic [DATA_W-1:0] RESET_CPSR = 32'h400001C0 | {27'd0, MODE_SVC};

   typedef enum logic [1:0] {
      OP_GENERAL = 2'd0,
      OP_CPSR    = 2'd1,
      OP_SPSR    = 2'd2,
      OP_USER    = 2'd3
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [REG_W-1:0]    reg_num;
      logic                fiq_user_flag;
      logic                fiq_range;
      logic [DATA_W-1:0]   write_data;
      logic [REG_W-1:0]    read_num;
      logic                new_ok;
      logic [BANK_W-1:0]   new_bank;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic mode_ok(input logic [MODE_W-1:0] mode);
      logic ok;
      unique case (mode)
         MODE_USR, MODE_SYS, MODE_SVC, MODE_ABT,
         MODE_UND, MODE_IRQ, MODE_FIQ: ok = 1'b1;
         default:                      ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic [BANK_W-1:0] bank_of(input logic [MODE_W-1:0] mode);
      logic [BANK_W-1:0] bank;
      unique case (mode)
         MODE_USR, MODE_SYS: bank = BANK_USR;
         MODE_SVC:           bank = BANK_SVC;
         MODE_ABT:           bank = BANK_ABT;
         MODE_UND:           bank = BANK_UND;
         MODE_IRQ:           bank = BANK_IRQ;
         MODE_FIQ:           bank = BANK_FIQ;
         default:            bank = BANK_USR;
      endcase
      return bank;
   endfunction

endpackage

// ----- design/abrf_front.sv -----
// Front end: accepts request beats and classifies them for the queue.
module abrf_front import abrf_pkg::*; (
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [REG_W-1:0]    req_reg_num,
   input  logic                req_fiq_user_flag,
   input  logic [DATA_W-1:0]   req_write_data,
   input  logic [REG_W-1:0]    req_read_num,
   input  queue_status_type    q_status,
   output logic                push,
   output entry_type           push_entry
);

   logic [MODE_W-1:0] new_mode;

   assign new_mode  = req_write_data[MODE_W-1:0];
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      push_entry.op            = op_type'(req_cmd);
      push_entry.reg_num       = req_reg_num;
      push_entry.fiq_user_flag = req_fiq_user_flag;
      push_entry.fiq_range     = (req_reg_num >= REG_W'(FIRST_FIQ_REG)) &&
                                 (req_reg_num < REG_W'(FIRST_FIQ_REG + NUM_FIQ_REGS));
      push_entry.write_data    = req_write_data;
      push_entry.read_num      = req_read_num;
      push_entry.new_ok        = mode_ok(new_mode);
      push_entry.new_bank      = bank_of(new_mode);
   end

endmodule

// ----- design/abrf_queue.sv -----
// Short queue of classified beats between front and back.
`include "arm_banked_register_file_macros.svh"
module abrf_queue import abrf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   entry_type            slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   function automatic logic [Q_PTR_W-1:0] bump(input logic [Q_PTR_W-1:0] ptr);
      return (ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      priority case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Q_DEPTH; i++) begin
            slot_ff[i] <= '0;
         end
      end else if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `ABRF_ASSERT_IMPL(q_no_overflow, push, !status.full)
   `ABRF_ASSERT_IMPL(q_no_underflow, pop, !status.empty)
   `ABRF_ASSERT_IMPL(q_count_bound, 1'b1, count_ff <= Q_CNT_W'(Q_DEPTH))

endmodule

// ----- design/abrf_back.sv -----
// Back end: executes register writes, bank swaps and drives the response beat.
`include "arm_banked_register_file_macros.svh"
module abrf_back import abrf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  entry_type           head,
   input  queue_status_type    q_status,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic [DATA_W-1:0]   rsp_cpsr_value,
   output logic [DATA_W-1:0]   rsp_spsr_value,
   output logic                rsp_bad_mode
);

   logic [DATA_W-1:0] active_ff   [NUM_GENERAL];
   logic [DATA_W-1:0] active_in   [NUM_GENERAL];
   logic [DATA_W-1:0] sp_ff       [NUM_BANKS];
   logic [DATA_W-1:0] sp_in       [NUM_BANKS];
   logic [DATA_W-1:0] lr_ff       [NUM_BANKS];
   logic [DATA_W-1:0] lr_in       [NUM_BANKS];
   logic [DATA_W-1:0] bspsr_ff    [NUM_BANKS];
   logic [DATA_W-1:0] bspsr_in    [NUM_BANKS];
   logic [DATA_W-1:0] fiq_ff      [NUM_FIQ_REGS];
   logic [DATA_W-1:0] fiq_in      [NUM_FIQ_REGS];
   logic [DATA_W-1:0] usr_ff      [NUM_FIQ_REGS];
   logic [DATA_W-1:0] usr_in      [NUM_FIQ_REGS];
   logic [DATA_W-1:0] cpsr_ff, cpsr_in;
   logic [DATA_W-1:0] spsr_ff, spsr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_read_ff, rsp_read_in;
   logic [DATA_W-1:0] rsp_cpsr_ff;
   logic [DATA_W-1:0] rsp_spsr_ff;
   logic              rsp_bad_ff, bad_in;

   logic [MODE_W-1:0]    cur_mode, new_mode;
   logic                 old_ok, user_view, same_bank;
   logic [BANK_W-1:0]    old_bank;
   logic [FIQ_IDX_W-1:0] fiq_idx;

   assign pop      = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign cur_mode = cpsr_ff[MODE_W-1:0];
   assign new_mode = head.write_data[MODE_W-1:0];
   assign old_ok   = mode_ok(cur_mode);
   assign old_bank = bank_of(cur_mode);
   assign user_view = (cur_mode == MODE_USR) || (cur_mode == MODE_SYS);
   assign same_bank = old_ok && (old_bank == head.new_bank);
   assign fiq_idx  = FIQ_IDX_W'(head.reg_num - REG_W'(FIRST_FIQ_REG));

   always_comb begin
      active_in = active_ff;
      sp_in     = sp_ff;
      lr_in     = lr_ff;
      bspsr_in  = bspsr_ff;
      fiq_in    = fiq_ff;
      usr_in    = usr_ff;
      cpsr_in   = cpsr_ff;
      spsr_in   = spsr_ff;
      bad_in    = 1'b0;
      unique case (head.op)
         OP_GENERAL: active_in[head.reg_num] = head.write_data;
         OP_CPSR: begin
            cpsr_in = head.write_data;
            if (new_mode != cur_mode) begin
               if (!head.new_ok) begin
                  bad_in = 1'b1;
               end else begin
                  if (cur_mode == MODE_FIQ) begin
                     for (int i = 0; i < NUM_FIQ_REGS; i++) begin
                        fiq_in[i]                   = active_ff[FIRST_FIQ_REG + i];
                        active_in[FIRST_FIQ_REG + i] = usr_ff[i];
                     end
                  end else if (new_mode == MODE_FIQ) begin
                     for (int i = 0; i < NUM_FIQ_REGS; i++) begin
                        usr_in[i]                   = active_ff[FIRST_FIQ_REG + i];
                        active_in[FIRST_FIQ_REG + i] = fiq_ff[i];
                     end
                  end
                  if (old_ok) begin
                     sp_in[old_bank]    = active_ff[SP_REG];
                     lr_in[old_bank]    = active_ff[LR_REG];
                     bspsr_in[old_bank] = spsr_ff;
                  end
                  active_in[SP_REG] = same_bank ? active_ff[SP_REG] : sp_ff[head.new_bank];
                  active_in[LR_REG] = same_bank ? active_ff[LR_REG] : lr_ff[head.new_bank];
                  spsr_in           = same_bank ? spsr_ff : bspsr_ff[head.new_bank];
               end
            end
         end
         OP_SPSR: spsr_in = head.write_data;
         OP_USER: begin
            priority if (head.reg_num == REG_W'(SP_REG) && !user_view) begin
               sp_in[BANK_USR] = head.write_data;
            end else if (head.reg_num == REG_W'(LR_REG) && !user_view) begin
               lr_in[BANK_USR] = head.write_data;
            end else if (head.fiq_user_flag && head.fiq_range) begin
               usr_in[fiq_idx] = head.write_data;
            end else begin
               active_in[head.reg_num] = head.write_data;
            end
         end
      endcase
      rsp_read_in = active_in[head.read_num];
   end

   always_comb begin
      priority if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cpsr_ff      <= RESET_CPSR;
         spsr_ff      <= '0;
         for (int i = 0; i < NUM_GENERAL; i++) begin
            active_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_BANKS; i++) begin
            sp_ff[i]    <= '0;
            lr_ff[i]    <= '0;
            bspsr_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_FIQ_REGS; i++) begin
            fiq_ff[i] <= '0;
            usr_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            active_ff <= active_in;
            sp_ff     <= sp_in;
            lr_ff     <= lr_in;
            bspsr_ff  <= bspsr_in;
            fiq_ff    <= fiq_in;
            usr_ff    <= usr_in;
            cpsr_ff   <= cpsr_in;
            spsr_ff   <= spsr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_read_ff <= rsp_read_in;
         rsp_cpsr_ff <= cpsr_in;
         rsp_spsr_ff <= spsr_in;
         rsp_bad_ff  <= bad_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_ff;
   assign rsp_cpsr_value = rsp_cpsr_ff;
   assign rsp_spsr_value = rsp_spsr_ff;
   assign rsp_bad_mode   = rsp_bad_ff;

   `ABRF_ASSERT_IMPL(bk_bad_keeps_sp, pop && bad_in, active_in[SP_REG] == active_ff[SP_REG])
   `ABRF_ASSERT_IMPL(bk_bad_only_cpsr, bad_in, head.op == OP_CPSR)
   `ABRF_ASSERT_NEXT(bk_pop_gives_rsp, pop, rsp_valid_ff)

endmodule

// ----- design/arm_banked_register_file.sv -----
// Top level of the ARM banked register file shadow.
// Each request beat is one register write (general, CPSR, SPSR or user-bank);
// a CPSR write that changes the mode swaps r13, r14, SPSR and, around FIQ,
// r8-r12 in the same cycle that the write executes. The block sustains one beat
// per clock unless the response stalls: the execute stage in the back end retires
// one queued beat per cycle into the response register; an accepted beat waits in
// the queue first. A two-entry queue between the classifying front end and the
// execute stage lets requests keep arriving while a response is stalled. Each
// response carries one register read after the write plus CPSR, SPSR and a flag
// for a CPSR write that named an unsupported mode.
module arm_banked_register_file import abrf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [REG_W-1:0]    req_reg_num,
   input  logic                req_fiq_user_flag,
   input  logic [DATA_W-1:0]   req_write_data,
   input  logic [REG_W-1:0]    req_read_num,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic [DATA_W-1:0]   rsp_cpsr_value,
   output logic [DATA_W-1:0]   rsp_spsr_value,
   output logic                rsp_bad_mode
);

   logic             push, pop;
   entry_type        push_entry, head;
   queue_status_type q_status;

   abrf_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_reg_num       (req_reg_num),
      .req_fiq_user_flag (req_fiq_user_flag),
      .req_write_data    (req_write_data),
      .req_read_num      (req_read_num),
      .q_status          (q_status),
      .push              (push),
      .push_entry        (push_entry)
   );

   abrf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   abrf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_cpsr_value (rsp_cpsr_value),
      .rsp_spsr_value (rsp_spsr_value),
      .rsp_bad_mode   (rsp_bad_mode)
   );

endmodule
